/* hw/rtl/fresnel_dielectric_reflectance_top_defines.svh */
// Assertion macros for the Fresnel reflectance block.
// Used by the top level; depends on nothing else.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_TOP_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FDR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdr assertion failed");

// Condition that must hold at every clock edge outside reset.
`define FDR_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> (cond)) \
		else $error("fdr assertion failed");

`endif

/* hw/rtl/fdr_pkg.sv */
// Shared constants and types for the Fresnel reflectance pipeline.
// No dependencies.
package fdr_pkg;
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] ONE = 17'd1 << FRAC_BITS;
	localparam logic [32:0] ONE_SQ = 33'd1 << (2 * FRAC_BITS);

	typedef struct packed {
		logic [16:0] c;
		logic [15:0] ei;
		logic [15:0] et;
		logic        tir;
	} tag_t;
endpackage

/* hw/rtl/fdr_ifs.sv */
// Valid/ready channels for items in and results out.
// No dependencies.
interface fdr_in_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] cos_incident;
	logic        [15:0] eta_incident;
	logic        [15:0] eta_transmitted;
	modport source(output valid, cos_incident, eta_incident, eta_transmitted, input ready);
	modport sink(input valid, cos_incident, eta_incident, eta_transmitted, output ready);
endinterface

interface fdr_out_if;
	logic        valid;
	logic        ready;
	logic [16:0] reflectance;
	logic        total_internal;
	modport source(output valid, reflectance, total_internal, input ready);
	modport sink(input valid, reflectance, total_internal, output ready);
endinterface

/* hw/rtl/fresnel_dielectric_reflectance_top.sv */
// Unpolarized dielectric Fresnel reflectance, fully pipelined: one item per cycle
// while not stalled. The pipe is a chain of two 17-stage square roots and two
// 17-stage dividers with registered stages between them; the whole pipe advances
// whenever the output register is empty or taken, so a stall holds every stage.
// Depends on fdr_pkg, fdr_ifs, fdr_sqrt, fdr_div and the defines header.
`include "fresnel_dielectric_reflectance_top_defines.svh"

module fresnel_dielectric_reflectance_top (
	input logic      clk,
	input logic      arst_n,
	fdr_in_if.sink   in_ch,
	fdr_out_if.source out_ch
);
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// clamp, zero-index fixup, swap
	logic signed [17:0] cs;
	logic        [17:0] cmag;
	logic        [15:0] ei0, et0;
	logic               neg;
	always_comb begin
		cs = in_ch.cos_incident;
		if (cs > $signed({1'b0, fdr_pkg::ONE})) cs = $signed({1'b0, fdr_pkg::ONE});
		if (cs < -$signed({1'b0, fdr_pkg::ONE})) cs = -$signed({1'b0, fdr_pkg::ONE});
		neg  = !(cs > 18'sd0);
		cmag = neg ? 18'(-cs) : 18'(cs);
		ei0  = (in_ch.eta_incident == 16'd0) ? 16'd1 : in_ch.eta_incident;
		et0  = (in_ch.eta_transmitted == 16'd0) ? 16'd1 : in_ch.eta_transmitted;
	end

	logic          v_s1, v_s2, v_s3;
	fdr_pkg::tag_t tag_s1, tag_s2, tag_s3;
	logic [32:0]   csq_s2, rad_s3;

	// post-sqrt / pre-div
	logic          v_si;
	logic [16:0]   sin_i;
	fdr_pkg::tag_t tag_si;
	logic          v_s4;
	logic [32:0]   n_s4;
	fdr_pkg::tag_t tag_s4;

	logic          v_d1;
	logic [16:0]   q_d1;
	fdr_pkg::tag_t tag_d1;
	logic          v_s5, v_s6;
	logic [31:0]   sq_s5;
	logic [32:0]   rad_s6;
	fdr_pkg::tag_t tag_s5, tag_s6;

	logic          v_ct;
	logic [16:0]   cos_t;
	fdr_pkg::tag_t tag_ct;
	logic          v_s7, v_s8;
	logic [32:0]   a_s7, b_s7, p_s7, q_s7;
	logic [33:0]   dpar_s8, spar_s8, dper_s8, sper_s8;
	fdr_pkg::tag_t tag_s7, tag_s8;

	logic          v_par, v_per;
	logic [16:0]   q_par, q_per;
	fdr_pkg::tag_t tag_par, tag_per;
	logic          v_s9;
	logic [33:0]   par2_s9, per2_s9;
	fdr_pkg::tag_t tag_s9;

	logic [16:0]   rpar, rper;
	logic [34:0]   sum;
	logic [17:0]   rsh;
	logic [16:0]   refl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_si;
			v_s5 <= v_d1;
			v_s6 <= v_s5;
			v_s7 <= v_ct;
			v_s8 <= v_s7;
			v_s9 <= v_par;
			out_ch.valid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= {cmag[16:0], neg ? et0 : ei0, neg ? ei0 : et0, 1'b0};

			csq_s2 <= 33'(tag_s1.c * tag_s1.c);
			tag_s2 <= tag_s1;
			rad_s3 <= fdr_pkg::ONE_SQ - csq_s2;
			tag_s3 <= tag_s2;

			n_s4   <= 33'(tag_si.ei * sin_i);
			tag_s4 <= tag_si;

			sq_s5      <= q_d1[15:0] * q_d1[15:0];
			tag_s5     <= {tag_d1.c, tag_d1.ei, tag_d1.et, q_d1[16]};
			rad_s6     <= fdr_pkg::ONE_SQ - {1'b0, sq_s5};
			tag_s6     <= tag_s5;

			a_s7   <= 33'(tag_ct.et * tag_ct.c);
			b_s7   <= 33'(tag_ct.ei * cos_t);
			p_s7   <= 33'(tag_ct.ei * tag_ct.c);
			q_s7   <= 33'(tag_ct.et * cos_t);
			tag_s7 <= tag_ct;

			dpar_s8 <= (a_s7 >= b_s7) ? {1'b0, a_s7 - b_s7} : {1'b0, b_s7 - a_s7};
			spar_s8 <= {1'b0, a_s7} + {1'b0, b_s7};
			dper_s8 <= (p_s7 >= q_s7) ? {1'b0, p_s7 - q_s7} : {1'b0, q_s7 - p_s7};
			sper_s8 <= {1'b0, p_s7} + {1'b0, q_s7};
			tag_s8  <= tag_s7;

			par2_s9 <= rpar * rpar;
			per2_s9 <= rper * rper;
			tag_s9  <= tag_par;

			out_ch.reflectance    <= tag_s9.tir ? fdr_pkg::ONE : refl;
			out_ch.total_internal <= tag_s9.tir;
		end
	end

	fdr_sqrt u_sqrt_i (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s3), .rad(rad_s3), .tag_in(tag_s3),
		.v_out(v_si), .root(sin_i), .tag_out(tag_si)
	);

	fdr_div u_div_sin (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s4), .num({17'd0, n_s4}), .den({18'd0, tag_s4.et}), .tag_in(tag_s4),
		.v_out(v_d1), .quo(q_d1), .tag_out(tag_d1)
	);

	fdr_sqrt u_sqrt_t (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s6), .rad(tag_s6.tir ? 33'd0 : rad_s6), .tag_in(tag_s6),
		.v_out(v_ct), .root(cos_t), .tag_out(tag_ct)
	);

	fdr_div u_div_par (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s8), .num({dpar_s8, 16'd0}), .den(spar_s8), .tag_in(tag_s8),
		.v_out(v_par), .quo(q_par), .tag_out(tag_par)
	);

	fdr_div u_div_per (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_s8), .num({dper_s8, 16'd0}), .den(sper_s8), .tag_in(tag_s8),
		.v_out(v_per), .quo(q_per), .tag_out(tag_per)
	);

	// zero denominator yields all ones; clamp gives 1.0
	assign rpar = (q_par > fdr_pkg::ONE) ? fdr_pkg::ONE : q_par;
	assign rper = (q_per > fdr_pkg::ONE) ? fdr_pkg::ONE : q_per;
	assign sum  = {1'b0, par2_s9} + {1'b0, per2_s9};
	assign rsh  = sum[34:17];
	assign refl = (rsh > {1'b0, fdr_pkg::ONE}) ? fdr_pkg::ONE : rsh[16:0];

	`FDR_ASSERT_IMP(a_tir_one, out_ch.valid && out_ch.total_internal,
		out_ch.reflectance == fdr_pkg::ONE)
	`FDR_ASSERT_IMP(a_refl_max, out_ch.valid, out_ch.reflectance <= fdr_pkg::ONE)
	`FDR_ASSERT_IMP(a_div_lanes, v_par || v_per, v_par && v_per && tag_par == tag_per)
	`FDR_ASSERT_IMP(a_stall_blocks, out_ch.valid && !out_ch.ready, !in_ch.ready)
endmodule

/* hw/rtl/fdr_sqrt.sv */
// Pipelined integer square root, one result bit per stage, 17 stages.
// Depends on fdr_pkg.
module fdr_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [32:0]   rad,
	input  fdr_pkg::tag_t tag_in,
	output logic          v_out,
	output logic [16:0]   root,
	output fdr_pkg::tag_t tag_out
);
	logic          v_s   [0:17];
	logic [33:0]   rem_s [0:17];
	logic [33:0]   res_s [0:17];
	fdr_pkg::tag_t tag_s [0:17];

	assign v_s[0]   = v_in;
	assign rem_s[0] = {1'b0, rad};
	assign res_s[0] = '0;
	assign tag_s[0] = tag_in;

	for (genvar k = 0; k < 17; k++) begin : g_stage
		localparam logic [33:0] BIT = 34'd1 << (32 - 2 * k);
		logic [33:0] t;
		logic        take;
		assign t    = res_s[k] + BIT;
		assign take = rem_s[k] >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? rem_s[k] - t : rem_s[k];
				res_s[k+1] <= take ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign v_out   = v_s[17];
	assign root    = res_s[17][16:0];
	assign tag_out = tag_s[17];
endmodule

/* hw/rtl/fdr_div.sv */
// Pipelined restoring divider: 17 quotient bits, one per stage.
// Quotient saturates bitwise; depends on fdr_pkg.
module fdr_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [49:0]   num,
	input  logic [33:0]   den,
	input  fdr_pkg::tag_t tag_in,
	output logic          v_out,
	output logic [16:0]   quo,
	output fdr_pkg::tag_t tag_out
);
	logic          v_s   [0:17];
	logic [49:0]   rem_s [0:17];
	logic [33:0]   den_s [0:17];
	logic [16:0]   quo_s [0:17];
	fdr_pkg::tag_t tag_s [0:17];

	assign v_s[0]   = v_in;
	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < 17; i++) begin : g_stage
		logic [49:0] dk;
		logic        take;
		assign dk   = {den_s[i], 16'd0} >> i;
		assign take = rem_s[i] >= dk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - dk : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= quo_s[i] | ({16'd0, take} << (16 - i));
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign v_out   = v_s[17];
	assign quo     = quo_s[17];
	assign tag_out = tag_s[17];
endmodule
